FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/gbkuhx_pkg.sv
// Shared types, codes and character helpers for the GBK / UCS-2 hex transcoder.
// No dependencies; used by the core and by its checker.
package gbkuhx_pkg;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam int  CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 1'b1;

  localparam logic DIR_UNI_TO_GBK = 1'b0;
  localparam logic DIR_GBK_TO_UNI = 1'b1;

  localparam int  ENTRIES_RESET = 32768;

  localparam logic [7:0]  GBK_LEAD_MIN = 8'h81;
  localparam logic [15:0] ASCII_LIMIT  = 16'h0080;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_LOWER_A = 8'h61;

  typedef logic [15:0] code_t;

  // Value of one hex character; anything that is not a hex digit counts as 0.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    case (c) inside
      [8'h30:8'h39]: v = 4'(c - CHAR_ZERO);
      [8'h41:8'h46]: v = 4'(c - CHAR_UPPER_A + 8'd10);
      [8'h61:8'h66]: v = 4'(c - CHAR_LOWER_A + 8'd10);
      default:       v = 4'h0;
    endcase
    return v;
  endfunction

  // Uppercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d <= 4'd9) begin
      c = CHAR_ZERO + {4'h0, d};
    end else begin
      c = CHAR_UPPER_A + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/gbkuhx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbkuhx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/gbk_unicode_hex_transcoder_core.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     opcode, text_byte, entry_index, entry_key, entry_value
// out       out_valid / out_ready   out_byte, last_of_run
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A load word or a word that only gathers part of a character is taken in idle and leaves the block there.
// A completed character below 0x80 goes straight to the emit state; any other runs a binary
// search (an issue and a compare state per step, at most SEARCH_STEPS steps), then emits.
// Reset clears the control state only; the table holds nothing until loaded.
// The next word is taken as soon as the last output byte sits in the output register;
// a stalled output byte holds the block in its emit state.
// Depends on gbkuhx_pkg and gbkuhx_ram.
module gbk_unicode_hex_transcoder_core #(
  parameter int ENTRIES_PER_HALF = 32768,
  parameter int SEARCH_STEPS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [7:0]                          text_byte,
  input  logic [15:0]                         entry_index,
  input  logic [15:0]                         entry_key,
  input  logic [15:0]                         entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                last_of_run,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbkuhx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data
);

  localparam int STORE_DEPTH = 2 * ENTRIES_PER_HALF;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int NW          = $clog2(ENTRIES_PER_HALF + 1);
  localparam int SW          = $clog2(SEARCH_STEPS + 1);
  localparam int N_RESET     = (gbkuhx_pkg::ENTRIES_RESET > ENTRIES_PER_HALF) ?
                               ENTRIES_PER_HALF : gbkuhx_pkg::ENTRIES_RESET;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]               state;
  logic                     dir;
  logic [NW-1:0]            n_eff;
  gbkuhx_pkg::code_t        pc;
  logic [1:0]               bg;
  gbkuhx_pkg::code_t        code;
  logic [AW-1:0]            lo_abs;
  logic [AW-1:0]            hi_abs;
  logic [AW-1:0]            mid_abs;
  logic [SW-1:0]            steps;
  gbkuhx_pkg::code_t        res;
  logic                     emit_hex;
  logic [1:0]               emit_idx;

  logic                     in_fire;
  logic                     cfg_fire;
  logic                     store_we;
  logic [31:0]              rdata;
  logic [AW-1:0]            mid_comb;
  logic [AW-1:0]            base;
  logic [AW-1:0]            hi_init;
  logic                     is_term;
  logic                     is_lead;
  gbkuhx_pkg::code_t        code_g;
  gbkuhx_pkg::code_t        pc_shift;
  gbkuhx_pkg::code_t        start_code;
  logic [NW-1:0]            n_sat;
  logic [1:0]               emit_last;
  logic [7:0]               emit_byte;
  logic                     load_out;
  logic [15:0]              key;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Table writes happen only in idle and searches only outside it, so a read
  // never overlaps a write to the same entry.
  assign store_we = in_fire && (opcode == gbkuhx_pkg::OP_LOAD) &&
                    ({1'b0, entry_index} < 17'(STORE_DEPTH));

  // Absolute addresses: base + lo + (hi - lo) / 2 equals lo_abs + (hi_abs - lo_abs) / 2.
  assign mid_comb = lo_abs + ((hi_abs - lo_abs) >> 1);
  assign key      = rdata[31:16];

  gbkuhx_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(entry_index)),
    .wdata ({entry_key, entry_value}),
    .raddr (mid_comb),
    .rdata (rdata)
  );

  always_comb begin
    base     = (dir == gbkuhx_pkg::DIR_GBK_TO_UNI) ? AW'(n_eff) : '0;
    hi_init  = base + AW'(n_eff) - AW'(1);
    is_term  = (bg == 2'd0) && (text_byte == 8'h00);
    is_lead  = (bg == 2'd0) && (text_byte >= gbkuhx_pkg::GBK_LEAD_MIN);
    code_g   = (bg == 2'd0) ? {8'h00, text_byte} : {pc[15:8], text_byte};
    pc_shift = {pc[11:0], gbkuhx_pkg::hex_val(text_byte)};
    start_code = (dir == gbkuhx_pkg::DIR_GBK_TO_UNI) ? code_g : pc_shift;
    if (cfg_data == 16'd0) begin
      n_sat = NW'(1);
    end else if ({1'b0, cfg_data} > 17'(ENTRIES_PER_HALF)) begin
      n_sat = NW'(ENTRIES_PER_HALF);
    end else begin
      n_sat = NW'(cfg_data);
    end
  end

  always_comb begin
    emit_last = emit_hex ? 2'd3 : ((res < gbkuhx_pkg::ASCII_LIMIT) ? 2'd0 : 2'd1);
    if (emit_hex) begin
      case (emit_idx)
        2'd0:    emit_byte = gbkuhx_pkg::hex_char(res[15:12]);
        2'd1:    emit_byte = gbkuhx_pkg::hex_char(res[11:8]);
        2'd2:    emit_byte = gbkuhx_pkg::hex_char(res[7:4]);
        default: emit_byte = gbkuhx_pkg::hex_char(res[3:0]);
      endcase
    end else begin
      emit_byte = ((emit_last == 2'd0) || (emit_idx == 2'd1)) ? res[7:0] : res[15:8];
    end
    load_out = (state == S_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dir       <= gbkuhx_pkg::DIR_UNI_TO_GBK;
      n_eff     <= NW'(N_RESET);
      pc        <= '0;
      bg        <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire && (opcode == gbkuhx_pkg::OP_CONVERT)) begin
            emit_idx <= 2'd0;
            if (is_term) begin
              res      <= '0;
              emit_hex <= 1'b0;
              state    <= S_EMIT;
            end else if ((dir == gbkuhx_pkg::DIR_GBK_TO_UNI) && is_lead) begin
              pc <= {text_byte, 8'h00};
              bg <= 2'd1;
            end else if ((dir == gbkuhx_pkg::DIR_UNI_TO_GBK) && (bg != 2'd3)) begin
              pc <= pc_shift;
              bg <= bg + 2'd1;
            end else begin
              // A character is complete: pass it through or start the search.
              pc       <= '0;
              bg       <= 2'd0;
              emit_hex <= dir;
              if (start_code < gbkuhx_pkg::ASCII_LIMIT) begin
                res   <= start_code;
                state <= S_EMIT;
              end else begin
                code   <= start_code;
                lo_abs <= base;
                hi_abs <= hi_init;
                steps  <= SW'(SEARCH_STEPS);
                state  <= S_ISSUE;
              end
            end
          end
        end
        S_ISSUE: begin
          mid_abs <= mid_comb;
          state   <= S_CMP;
        end
        S_CMP: begin
          if (code == key) begin
            res   <= rdata[15:0];
            state <= S_EMIT;
          end else begin
            if (code > key) begin
              lo_abs <= mid_abs;
            end else begin
              hi_abs <= mid_abs;
            end
            steps <= steps - SW'(1);
            if (steps == SW'(1)) begin
              res   <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (load_out) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (load_out) begin
        out_valid   <= 1'b1;
        out_byte    <= emit_byte;
        last_of_run <= (emit_idx == emit_last);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_fire) begin
        case (cfg_index)
          gbkuhx_pkg::CFG_DIRECTION: begin
            dir <= cfg_data[0];
            pc  <= '0;
            bg  <= 2'd0;
          end
          gbkuhx_pkg::CFG_ENTRIES: n_eff <= n_sat;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/gbkuhx_checker.sv
// Port-level checks for the GBK / UCS-2 hex transcoder core, bound to the core module.
// Depends on assert_macros.svh and gbkuhx_pkg.
`include "assert_macros.svh"

module gbkuhx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  logic load_fire;

  assign load_fire = in_valid && in_ready && (opcode == gbkuhx_pkg::OP_LOAD);

  // A stalled output word holds its value.
  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_run))

  // While the bytes of one word are still being delivered, no new word is taken.
  `ASSERT_IMP(a_run_blocks_input, clk, rst, out_valid && !last_of_run, !in_ready)

  // A load word produces no output.
  `ASSERT_NXT(a_load_silent, clk, rst, load_fire, !$rose(out_valid))

  // After a load word the block is ready again in the next cycle.
  `ASSERT_NXT(a_load_one_cycle, clk, rst, load_fire, in_ready)

endmodule

bind gbk_unicode_hex_transcoder_core gbkuhx_checker u_gbkuhx_checker (.*);
